### design/advection_step_limit_min_top_assert.svh
// Assertion macros for the step limit block checkers.
// Needs signals named clock and reset in the scope of use.
`ifndef ADVECTION_STEP_LIMIT_MIN_TOP_ASSERT_SVH
`define ADVECTION_STEP_LIMIT_MIN_TOP_ASSERT_SVH

// Clocked property, switched off while reset is high.
`define ASL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property, checked through reset as well.
`define ASL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/asl_pkg.sv
// Shared constants, types and ALU codes for the advection step limit block.
// No dependencies.
package asl_pkg;

   localparam int DIM       = 3;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int SQ_W      = 64;
   // trial subtract width: root remainder plus two fresh bits
   localparam int SUB_W     = DATA_W + 3;
   // dividend: radius doubled, shifted up by the fraction
   localparam int NUM_W     = DATA_W + 1 + FRAC_BITS;
   localparam int CNT_W     = $clog2((NUM_W > DATA_W) ? NUM_W : DATA_W);
   localparam int IDX_W     = 2;

   localparam logic [DATA_W-1:0] STEP_MAX = '1;

   typedef enum logic {
      ALU_SQUARE,
      ALU_TRY_SUB
   } asl_op_type;

   typedef struct packed {
      asl_op_type        op;
      logic [DATA_W-1:0] comp;
      logic [SUB_W-1:0]  a;
      logic [SUB_W-1:0]  b;
   } asl_alu_req_type;

   typedef struct packed {
      logic            ge;
      logic [SQ_W-1:0] value;
   } asl_alu_rsp_type;

endpackage

### design/asl_alu.sv
// Shared arithmetic unit: magnitude square, or trial subtract with compare.
// Depends on asl_pkg.
module asl_alu
   import asl_pkg::*;
(
   input  asl_alu_req_type alu_req,
   output asl_alu_rsp_type alu_rsp
);

   logic [DATA_W-1:0] mag;
   logic [SUB_W:0]    diff_wide;

   always_comb begin
      mag       = alu_req.comp[DATA_W-1] ? (~alu_req.comp + 1'b1) : alu_req.comp;
      diff_wide = {1'b0, alu_req.a} - {1'b0, alu_req.b};
      alu_rsp   = '0;
      case (alu_req.op)
         ALU_SQUARE: begin
            alu_rsp.value = SQ_W'(mag) * SQ_W'(mag);
         end
         ALU_TRY_SUB: begin
            // no borrow means a >= b
            alu_rsp.ge    = ~diff_wide[SUB_W];
            alu_rsp.value = SQ_W'(diff_wide[SUB_W-1:0]);
         end
         default: begin
            alu_rsp = '0;
         end
      endcase
   end

endmodule

### design/advection_step_limit_min_top.sv
// An element with zero peak speed skips the division and goes straight to the result.
// One element at a time: req_stall is high while an element is in work.
// All squares, root bits and quotient bits go through the single shared ALU.
// Reset (synchronous, active high): sequencer idle, no result beat, running minimum empty.
module advection_step_limit_min_top
   import asl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_node_vel_x,
   input  logic signed [DATA_W-1:0] req_node_vel_y,
   input  logic signed [DATA_W-1:0] req_node_vel_z,
   input  logic signed [DATA_W-1:0] req_elem_vel_x,
   input  logic signed [DATA_W-1:0] req_elem_vel_y,
   input  logic signed [DATA_W-1:0] req_elem_vel_z,
   input  logic        [DATA_W-1:0] req_inner_radius,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic        [DATA_W-1:0] rsp_element_step,
   output logic        [DATA_W-1:0] rsp_min_step,
   output logic                     rsp_min_is_zero
);

   // Sequence per element:
   //   square and accumulate the node components, 32 root steps,
   //   the same for the element vector, then, unless the peak speed is zero, NUM_W restoring division steps.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_ROOT,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type          state_ff,      state_in;
   logic [IDX_W-1:0]   idx_ff,        idx_in;
   logic               vec_ff,        vec_in;       // 0 node vector, 1 element vector
   logic [CNT_W-1:0]   cnt_ff,        cnt_in;
   logic [DATA_W-1:0]  node_ff [3];
   logic [DATA_W-1:0]  node_in [3];
   logic [DATA_W-1:0]  elem_ff [3];
   logic [DATA_W-1:0]  elem_in [3];
   logic [DATA_W-1:0]  radius_ff,     radius_in;
   logic [SQ_W-1:0]    prod_ff,       prod_in;
   logic [SQ_W-1:0]    acc_ff,        acc_in;       // sum of squares, then root operand
   logic [SUB_W-1:0]   rem_ff,        rem_in;       // root or division remainder
   logic [DATA_W-1:0]  root_ff,       root_in;
   logic [DATA_W-1:0]  node_len_ff,   node_len_in;
   logic [DATA_W-1:0]  speed_ff,      speed_in;
   logic               zero_speed_ff, zero_speed_in;
   logic [NUM_W-1:0]   num_ff,        num_in;
   logic [NUM_W-1:0]   quo_ff,        quo_in;
   logic [DATA_W-1:0]  min_ff,        min_in;
   logic               seen_ff,       seen_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [DATA_W-1:0]  rsp_step_ff,   rsp_step_in;
   logic [DATA_W-1:0]  rsp_min_ff,    rsp_min_in;
   logic               rsp_zero_ff,   rsp_zero_in;

   asl_alu_req_type    alu_req;
   asl_alu_rsp_type    alu_rsp;

   logic [DATA_W-1:0]  sel_comp;
   logic [SUB_W-1:0]   root_rem_sh;
   logic [DATA_W:0]    div_rem_sh;
   logic [DATA_W-1:0]  root_next;
   logic [DATA_W-1:0]  peak;
   logic [DATA_W-1:0]  step;
   logic [DATA_W-1:0]  new_min;

   // ---------------------------------------------------------------------------------------
   // Operand selection for the shared unit
   // ---------------------------------------------------------------------------------------
   always_comb begin
      sel_comp    = vec_ff ? elem_ff[idx_ff] : node_ff[idx_ff];
      // root remainder stays below 2^33, so its low 33 bits carry it all
      root_rem_sh = {rem_ff[DATA_W:0], acc_ff[SQ_W-1 -: 2]};
      // division remainder stays below the divisor
      div_rem_sh  = {rem_ff[DATA_W-1:0], num_ff[NUM_W-1]};

      alu_req.op   = (state_ff == ST_SQ_MUL) ? ALU_SQUARE : ALU_TRY_SUB;
      alu_req.comp = sel_comp;
      if (state_ff == ST_DIV) begin
         alu_req.a = SUB_W'(div_rem_sh);
         alu_req.b = SUB_W'(speed_ff);
      end else begin
         alu_req.a = root_rem_sh;
         alu_req.b = {1'b0, root_ff, 2'b01};
      end
   end

   asl_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // ---------------------------------------------------------------------------------------
   // Step result, saturated, and running minimum
   // ---------------------------------------------------------------------------------------
   always_comb begin
      root_next = {root_ff[DATA_W-2:0], alu_rsp.ge};
      peak      = (node_len_ff >= root_next) ? node_len_ff : root_next;

      if (zero_speed_ff) begin
         step = (radius_ff == '0) ? '0 : STEP_MAX;
      end else if (|quo_ff[NUM_W-1:DATA_W]) begin
         step = STEP_MAX;
      end else begin
         step = quo_ff[DATA_W-1:0];
      end

      new_min = (!seen_ff || (step < min_ff)) ? step : min_ff;
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      vec_in        = vec_ff;
      cnt_in        = cnt_ff;
      node_in       = node_ff;
      elem_in       = elem_ff;
      radius_in     = radius_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      node_len_in   = node_len_ff;
      speed_in      = speed_ff;
      zero_speed_in = zero_speed_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      min_in        = min_ff;
      seen_in       = seen_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_step_in   = rsp_step_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_zero_in   = rsp_zero_ff;

      // result beat taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               node_in   = '{req_node_vel_x, req_node_vel_y, req_node_vel_z};
               elem_in   = '{req_elem_vel_x, req_elem_vel_y, req_elem_vel_z};
               radius_in = req_inner_radius;
               idx_in    = '0;
               vec_in    = 1'b0;
               acc_in    = '0;
               state_in  = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            prod_in  = alu_rsp.value;
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            acc_in = acc_ff + prod_ff;
            if (idx_ff == IDX_W'(DIM - 1)) begin
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CNT_W'(DATA_W - 1);
               state_in = ST_ROOT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_ROOT: begin
            acc_in  = acc_ff << 2;
            rem_in  = alu_rsp.ge ? alu_rsp.value[SUB_W-1:0] : root_rem_sh;
            root_in = root_next;
            if (cnt_ff == '0) begin
               if (!vec_ff) begin
                  node_len_in = root_next;
                  vec_in      = 1'b1;
                  idx_in      = '0;
                  acc_in      = '0;
                  state_in    = ST_SQ_MUL;
               end else begin
                  speed_in = peak;
                  if (peak == '0) begin
                     zero_speed_in = 1'b1;
                     state_in      = ST_DONE;
                  end else begin
                     zero_speed_in = 1'b0;
                     rem_in        = '0;
                     num_in        = {radius_ff, 1'b0, {FRAC_BITS{1'b0}}};
                     quo_in        = '0;
                     cnt_in        = CNT_W'(NUM_W - 1);
                     state_in      = ST_DIV;
                  end
               end
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV: begin
            rem_in = alu_rsp.ge ? alu_rsp.value[SUB_W-1:0] : SUB_W'(div_rem_sh);
            quo_in = {quo_ff[NUM_W-2:0], alu_rsp.ge};
            num_in = num_ff << 1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            // output register free or emptying this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               min_in       = new_min;
               seen_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_step_in  = step;
               rsp_min_in   = new_min;
               rsp_zero_in  = (new_min == '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         min_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      vec_ff        <= vec_in;
      cnt_ff        <= cnt_in;
      node_ff       <= node_in;
      elem_ff       <= elem_in;
      radius_ff     <= radius_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      node_len_ff   <= node_len_in;
      speed_ff      <= speed_in;
      zero_speed_ff <= zero_speed_in;
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      rsp_step_ff   <= rsp_step_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_zero_ff   <= rsp_zero_in;
   end

   // busy from the accepting edge until the sequencer is idle again
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_element_step = rsp_step_ff;
   assign rsp_min_step     = rsp_min_ff;
   assign rsp_min_is_zero  = rsp_zero_ff;

endmodule

### design/asl_checker.sv
// Port-level checker for the advection step limit top level, with its bind.
// Depends on asl_pkg and advection_step_limit_min_top_assert.svh.
`include "advection_step_limit_min_top_assert.svh"

module asl_checker
   import asl_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [DATA_W-1:0] rsp_element_step,
   input logic [DATA_W-1:0] rsp_min_step,
   input logic              rsp_min_is_zero
);

   logic                  req_beat;
   logic                  rsp_wait;
   logic                  min_zero;
   logic [2*DATA_W:0]     rsp_data;

   assign req_beat = req_valid && !req_stall;
   assign rsp_wait = rsp_valid && rsp_stall;
   assign min_zero = (rsp_min_step == '0);
   assign rsp_data = {rsp_element_step, rsp_min_step, rsp_min_is_zero};

   // one element at a time: busy straight after taking a beat
   `ASL_ASSERT(a_busy_after_req, req_beat |=> req_stall, "block took a second element")

   // running minimum never exceeds the element's own step
   `ASL_ASSERT(a_min_le_step, rsp_valid |-> (rsp_min_step <= rsp_element_step), "min above step")

   // zero flag agrees with the minimum
   `ASL_ASSERT_ALWAYS(a_zero_flag, rsp_valid |-> (rsp_min_is_zero == min_zero), "bad zero flag")

   // stalled result beat holds
   `ASL_ASSERT(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_data), "stalled beat changed")

endmodule

bind advection_step_limit_min_top asl_checker u_asl_checker (.*);
